FILE: sv/ant_pkg.sv
// Shared types, codes and constants of the aging neighbor table.
package ant_pkg;

   localparam int DATA_W          = 16;
   localparam int STATUS_W        = 3;
   localparam int COUNT_OUT_W     = 5;
   localparam int STEP_W          = $clog2(DATA_W + 1);
   localparam int MAX_ENTRIES_DEF = 16;
   localparam logic [DATA_W-1:0] TIMEOUT_RESET = 16'd3600;

   typedef enum logic [1:0] {
      OP_ANNOUNCE = 2'd0,
      OP_FORWARD  = 2'd1,
      OP_TICK     = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_REFRESHED = 3'd0,
      STATUS_ADDED     = 3'd1,
      STATUS_DROPPED   = 3'd2,
      STATUS_FORWARDED = 3'd3,
      STATUS_NONE      = 3'd4,
      STATUS_TICK      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANNOUNCE,
      ST_TICK,
      ST_DIVIDE,
      ST_FETCH,
      ST_DONE
   } state_type;

endpackage

FILE: sv/ant_store.sv
// Entry memory: neighbor addresses and countdowns, one write and one registered read port.
module ant_store
   import ant_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            wr_addr_en,
   input  logic                            wr_cnt_en,
   input  logic [$clog2(MAX_ENTRIES)-1:0]  wr_idx,
   input  logic [DATA_W-1:0]               wr_addr,
   input  logic [DATA_W-1:0]               wr_cnt,
   input  logic [$clog2(MAX_ENTRIES)-1:0]  rd_idx,
   output logic [DATA_W-1:0]               rd_addr,
   output logic [DATA_W-1:0]               rd_cnt
);

   logic [DATA_W-1:0] addr_mem_ff [MAX_ENTRIES];
   logic [DATA_W-1:0] cnt_mem_ff  [MAX_ENTRIES];
   logic [DATA_W-1:0] rd_addr_ff;
   logic [DATA_W-1:0] rd_cnt_ff;

   always_ff @(posedge clock) begin
      if (wr_addr_en) begin
         addr_mem_ff[wr_idx] <= wr_addr;
      end
      rd_addr_ff <= addr_mem_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (wr_cnt_en) begin
         cnt_mem_ff[wr_idx] <= wr_cnt;
      end
      rd_cnt_ff <= cnt_mem_ff[rd_idx];
   end

   assign rd_addr = rd_addr_ff;
   assign rd_cnt  = rd_cnt_ff;

endmodule

FILE: sv/ant_modulo.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ant_modulo
   import ant_pkg::*;
#(
   parameter int CNT_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [CNT_W-1:0]  remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  divisor_ff, divisor_in;
   logic [CNT_W:0]    trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, shift_ff[DATA_W-1]};
      if (start) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(DATA_W);
         shift_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so one subtract suffices.
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         shift_in = {shift_ff[DATA_W-2:0], 1'b0};
         step_in  = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/aging_neighbor_table.sv
// Aging neighbor table: an ordered list of neighbor addresses with per-entry tick countdowns.
// Request channel (req_valid/req_stall) carries announcements, forward requests and time
// ticks; each accepted transaction except an unused request type yields exactly one response
// transaction on rsp_valid/rsp_stall. The timeout register is written through csr_wr_en and
// csr_wr_data; the user must write it only while the block is idle, since the block itself
// does not enforce this. The sequencer walks the entry memory through its single registered
// read port, one entry per cycle. An announcement or a tick reads the live entries in turn
// (a refresh stops at the matching entry); a forward request first runs the 16 steps of the
// bit-serial remainder unit and then one memory read; a forward with an empty table goes
// straight to the response. The next request can be accepted in the same cycle that the
// response appears. req_stall is high while a transaction is in work.
// A response that waits on rsp_stall holds in the output register and does not block the
// next request; only a second finished result waits in the sequencer until the first leaves.
// Synchronous reset empties the table, sets the timeout to 3600 ticks and drops any pending
// response. The entry memory needs no clearing, since only live entries are ever read.
module aging_neighbor_table
   import ant_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_type,
   input  logic [DATA_W-1:0]      req_neighbor_addr,
   input  logic [DATA_W-1:0]      req_rand_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [DATA_W-1:0]      rsp_next_hop,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [COUNT_OUT_W-1:0] rsp_expired_count,
   input  logic                   csr_wr_en,
   input  logic [DATA_W-1:0]      csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [DATA_W-1:0] timeout_ff;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic [CNT_W-1:0] gone_ff, gone_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [DATA_W-1:0] addr_ff, addr_in;
   status_type       res_status_ff, res_status_in;
   logic [DATA_W-1:0] res_hop_ff, res_hop_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]      rsp_next_hop_ff, rsp_next_hop_in;
   logic [COUNT_OUT_W-1:0] rsp_entry_count_ff, rsp_entry_count_in;
   logic [COUNT_OUT_W-1:0] rsp_expired_count_ff, rsp_expired_count_in;

   logic              wr_addr_en;
   logic              wr_cnt_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [DATA_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_cnt;
   logic [IDX_W-1:0]  rd_idx;
   logic [DATA_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_cnt;

   logic              div_start;
   logic              div_done;
   logic [CNT_W-1:0]  div_rem;

   ant_store #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_store (
      .clock      (clock),
      .wr_addr_en (wr_addr_en),
      .wr_cnt_en  (wr_cnt_en),
      .wr_idx     (wr_idx),
      .wr_addr    (wr_addr),
      .wr_cnt     (wr_cnt),
      .rd_idx     (rd_idx),
      .rd_addr    (rd_addr),
      .rd_cnt     (rd_cnt)
   );

   ant_modulo #(
      .CNT_W(CNT_W)
   ) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_rand_value),
      .divisor   (live_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in             = state_ff;
      live_in              = live_ff;
      idx_in               = idx_ff;
      keep_in              = keep_ff;
      gone_in              = gone_ff;
      pend_in              = 1'b0;
      pend_idx_in          = pend_idx_ff;
      addr_in              = addr_ff;
      res_status_in        = res_status_ff;
      res_hop_in           = res_hop_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_status_in        = rsp_status_ff;
      rsp_next_hop_in      = rsp_next_hop_ff;
      rsp_entry_count_in   = rsp_entry_count_ff;
      rsp_expired_count_in = rsp_expired_count_ff;
      wr_addr_en           = 1'b0;
      wr_cnt_en            = 1'b0;
      wr_idx               = live_ff[IDX_W-1:0];
      wr_addr              = addr_ff;
      wr_cnt               = timeout_ff;
      rd_idx               = idx_ff[IDX_W-1:0];
      div_start            = 1'b0;
      req_stall            = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in     = '0;
               keep_in    = '0;
               gone_in    = '0;
               res_hop_in = '0;
               case (op_type'(req_type))
                  OP_ANNOUNCE: begin
                     addr_in  = req_neighbor_addr;
                     state_in = ST_ANNOUNCE;
                  end
                  OP_FORWARD: begin
                     if (live_ff == '0) begin
                        res_status_in = STATUS_NONE;
                        state_in      = ST_DONE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIVIDE;
                     end
                  end
                  OP_TICK: begin
                     state_in = ST_TICK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_ANNOUNCE: begin
            // Each cycle checks the entry read last cycle and issues the next read.
            if (pend_ff && (rd_addr == addr_ff)) begin
               wr_cnt_en     = 1'b1;
               wr_idx        = pend_idx_ff;
               res_status_in = STATUS_REFRESHED;
               state_in      = ST_DONE;
            end else if (idx_ff < live_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[IDX_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
            end else if (live_ff >= CNT_W'(MAX_ENTRIES)) begin
               res_status_in = STATUS_DROPPED;
               state_in      = ST_DONE;
            end else begin
               wr_addr_en    = 1'b1;
               wr_cnt_en     = 1'b1;
               live_in       = live_ff + CNT_W'(1);
               res_status_in = STATUS_ADDED;
               state_in      = ST_DONE;
            end
         end

         ST_TICK: begin
            // Survivors are written back at the keep index, which never passes the read index.
            if (pend_ff) begin
               if (rd_cnt <= DATA_W'(1)) begin
                  gone_in = gone_ff + CNT_W'(1);
               end else begin
                  wr_addr_en = 1'b1;
                  wr_cnt_en  = 1'b1;
                  wr_idx     = keep_ff[IDX_W-1:0];
                  wr_addr    = rd_addr;
                  wr_cnt     = rd_cnt - DATA_W'(1);
                  keep_in    = keep_ff + CNT_W'(1);
               end
            end
            if (idx_ff < live_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + CNT_W'(1);
            end else begin
               live_in       = keep_in;
               res_status_in = STATUS_TICK;
               state_in      = ST_DONE;
            end
         end

         ST_DIVIDE: begin
            if (div_done) begin
               rd_idx   = div_rem[IDX_W-1:0];
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            res_hop_in    = rd_addr;
            res_status_in = STATUS_FORWARDED;
            state_in      = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = res_status_ff;
               rsp_next_hop_in    = res_hop_ff;
               rsp_entry_count_in = COUNT_OUT_W'(live_ff);
               if (res_status_ff == STATUS_TICK) begin
                  rsp_expired_count_in = COUNT_OUT_W'(gone_ff);
               end else begin
                  rsp_expired_count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff               <= idx_in;
      keep_ff              <= keep_in;
      gone_ff              <= gone_in;
      pend_idx_ff          <= pend_idx_in;
      addr_ff              <= addr_in;
      res_status_ff        <= res_status_in;
      res_hop_ff           <= res_hop_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_next_hop_ff      <= rsp_next_hop_in;
      rsp_entry_count_ff   <= rsp_entry_count_in;
      rsp_expired_count_ff <= rsp_expired_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_next_hop      = rsp_next_hop_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;
   assign rsp_expired_count = rsp_expired_count_ff;

endmodule

FILE: tb/sv/aging_neighbor_table_test.sv
// Self-checking testbench for the aging neighbor table: directed and random traffic.
module aging_neighbor_table_test;
   import ant_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 310;
   localparam int POOL_SIZE = 20;

   typedef struct packed {
      status_type             status;
      logic [DATA_W-1:0]      next_hop;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic [COUNT_OUT_W-1:0] expired_count;
   } table_reply_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_type = 2'd0;
   logic [DATA_W-1:0]      req_neighbor_addr = '0;
   logic [DATA_W-1:0]      req_rand_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [DATA_W-1:0]      rsp_next_hop;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic [COUNT_OUT_W-1:0] rsp_expired_count;
   logic                   csr_wr_en = 1'b0;
   logic [DATA_W-1:0]      csr_wr_data = '0;

   // Shadow copy of the table and the timeout register.
   logic [DATA_W-1:0] shadow_addr [MAX_ENTRIES_DEF];
   logic [DATA_W-1:0] shadow_life [MAX_ENTRIES_DEF];
   int                shadow_count = 0;
   logic [DATA_W-1:0] shadow_timeout = TIMEOUT_RESET;

   table_reply_type expected_replies [$];
   table_reply_type oldest_reply;
   int              mismatch_count = 0;
   int              sender_gap_pct = 0;
   int              sink_stall_pct = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   aging_neighbor_table dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_neighbor_addr (req_neighbor_addr),
      .req_rand_value    (req_rand_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_next_hop      (rsp_next_hop),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_expired_count (rsp_expired_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // Applies one request to the shadow table; returns 0 when no reply is due.
   function automatic bit predict_table_reply(input logic [1:0] kind,
                                              input logic [DATA_W-1:0] addr,
                                              input logic [DATA_W-1:0] rnd,
                                              output table_reply_type reply);
      bit found;
      int kept;
      int gone;
      reply = '0;
      found = 1'b0;
      kept = 0;
      gone = 0;
      if (kind == OP_ANNOUNCE) begin
         for (int i = 0; i < shadow_count; i++) begin
            if (!found && shadow_addr[i] == addr) begin
               shadow_life[i] = shadow_timeout;
               found = 1'b1;
            end
         end
         if (found) begin
            reply.status = STATUS_REFRESHED;
         end else if (shadow_count >= MAX_ENTRIES_DEF) begin
            reply.status = STATUS_DROPPED;
         end else begin
            shadow_addr[shadow_count] = addr;
            shadow_life[shadow_count] = shadow_timeout;
            shadow_count++;
            reply.status = STATUS_ADDED;
         end
      end else if (kind == OP_FORWARD) begin
         if (shadow_count == 0) begin
            reply.status = STATUS_NONE;
         end else begin
            reply.status = STATUS_FORWARDED;
            reply.next_hop = shadow_addr[rnd % shadow_count];
         end
      end else if (kind == OP_TICK) begin
         // A countdown of zero or one runs out on this tick; survivors close ranks.
         for (int i = 0; i < shadow_count; i++) begin
            if (shadow_life[i] <= 1) begin
               gone++;
            end else begin
               shadow_addr[kept] = shadow_addr[i];
               shadow_life[kept] = shadow_life[i] - 1'b1;
               kept++;
            end
         end
         shadow_count = kept;
         reply.status = STATUS_TICK;
         reply.expired_count = COUNT_OUT_W'(gone);
      end else begin
         return 1'b0;
      end
      reply.entry_count = COUNT_OUT_W'(shadow_count);
      return 1'b1;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [DATA_W-1:0] addr,
                            input logic [DATA_W-1:0] rnd);
      table_reply_type reply;
      if ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_neighbor_addr <= addr;
      req_rand_value    <= rnd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_table_reply(kind, addr, rnd, reply)) begin
         expected_replies.push_back(reply);
      end
   endtask

   // Holds the sender off until every reply is in and the sequencer has gone quiet.
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      shadow_timeout = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_item(OP_FORWARD, 16'h0000, 16'hFFFF);
      send_item(OP_TICK, 16'hFFFF, 16'h0000);
      send_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
      send_item(OP_FORWARD, 16'h0000, 16'h0000);
   endtask

   task automatic test_address_extremes();
      send_item(OP_ANNOUNCE, 16'h0000, 16'h0000);
      send_item(OP_ANNOUNCE, 16'hFFFF, 16'hFFFF);
      send_item(OP_ANNOUNCE, 16'h0000, 16'h5A5A);
      send_item(OP_FORWARD, 16'hFFFF, 16'h0000);
      send_item(OP_FORWARD, 16'h0000, 16'hFFFF);
      send_item(OP_TICK, 16'h0000, 16'h0000);
   endtask

   // A timeout of zero must expire an entry at the very next tick, like a timeout of one.
   task automatic test_zero_timeout();
      settle_idle();
      write_timeout(16'h0000);
      send_item(OP_ANNOUNCE, 16'h1234, 16'h0000);
      send_item(OP_ANNOUNCE, 16'h0000, 16'h0000);
      send_item(OP_ANNOUNCE, 16'hFFFF, 16'h0000);
      send_item(OP_TICK, 16'h0000, 16'h0000);
      settle_idle();
      write_timeout(16'h0001);
      send_item(OP_ANNOUNCE, 16'hA5A5, 16'h0000);
      send_item(OP_TICK, 16'h0000, 16'h0000);
   endtask

   task automatic test_table_full();
      settle_idle();
      write_timeout(16'h0002);
      for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
         send_item(OP_ANNOUNCE, 16'h0100 + DATA_W'(i), 16'($urandom));
      end
      send_item(OP_ANNOUNCE, 16'hBEEF, 16'h0000);
      send_item(OP_ANNOUNCE, 16'h0105, 16'h0000);
      send_item(OP_FORWARD, 16'h0000, 16'h000F);
      send_item(OP_TICK, 16'h0000, 16'h0000);
      send_item(OP_TICK, 16'h0000, 16'h0000);
   endtask

   // Announcements mostly come from a small address pool so that entries get refreshed,
   // the table fills up and ticks expire them; the rest is random addresses and noise.
   task automatic test_random_traffic(input logic [DATA_W-1:0] timeout_value,
                                      input int gap_pct, input int stall_pct);
      logic [DATA_W-1:0] addr_pool [POOL_SIZE];
      logic [1:0]        kind;
      logic [DATA_W-1:0] addr;
      int                roll;
      settle_idle();
      write_timeout(timeout_value);
      sender_gap_pct = gap_pct;
      sink_stall_pct = stall_pct;
      foreach (addr_pool[i]) addr_pool[i] = 16'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         roll = $urandom_range(99);
         if (roll < 45) begin
            kind = OP_ANNOUNCE;
         end else if (roll < 67) begin
            kind = OP_FORWARD;
         end else if (roll < 95) begin
            kind = OP_TICK;
         end else begin
            kind = REQ_UNUSED;
         end
         if ($urandom_range(9) == 0) begin
            addr = 16'($urandom);
         end else begin
            addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
         end
         send_item(kind, addr, 16'($urandom));
         if ($urandom_range(199) == 0) begin
            settle_idle();
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected transaction: status %0d next_hop %0h", rsp_status, rsp_next_hop);
            mismatch_count++;
         end else begin
            oldest_reply = expected_replies.pop_front();
            if (rsp_status !== oldest_reply.status) begin
               $error("status: expected %0d, got %0d", oldest_reply.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_next_hop !== oldest_reply.next_hop) begin
               $error("next_hop: expected %0h, got %0h", oldest_reply.next_hop, rsp_next_hop);
               mismatch_count++;
            end
            if (rsp_entry_count !== oldest_reply.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      oldest_reply.entry_count, rsp_entry_count);
               mismatch_count++;
            end
            if (rsp_expired_count !== oldest_reply.expired_count) begin
               $error("expired_count: expected %0d, got %0d",
                      oldest_reply.expired_count, rsp_expired_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      sender_gap_pct = 10;
      sink_stall_pct = 73;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_address_extremes();
      test_zero_timeout();
      test_table_full();
      test_random_traffic(16'd1, 10, 73);
      test_random_traffic(16'd4, 10, 73);
      test_random_traffic(16'd9, 73, 10);
      test_random_traffic(16'($urandom_range(2, 30)), 73, 10);
      test_random_traffic(16'd2, 0, 0);
      test_random_traffic(16'hFFFF, 0, 0);
      settle_idle();
      if (mismatch_count == 0) begin
         $display("aging_neighbor_table_test passed");
      end else begin
         $display("aging_neighbor_table_test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("aging_neighbor_table_test failed");
      $finish;
   end

endmodule

FILE: files.f
sv/ant_pkg.sv
sv/ant_store.sv
sv/ant_modulo.sv
sv/aging_neighbor_table.sv
tb/sv/aging_neighbor_table_test.sv
